/* design/svm_pkg.sv */
// Shared constants and types of the supply voltage monitor.
`timescale 1ns / 1ps
`default_nettype none
package svm_pkg;

	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned VOLT_W   = 10;
	localparam int unsigned GAIN_W   = 8;
	localparam int unsigned ACC_W    = 12;
	localparam int unsigned STAT_W   = 2;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 10;

	localparam logic [VOLT_W-1:0] SAMPLE_CLAMP = 10'd992;
	localparam logic [GAIN_W-1:0] GAIN_RESET   = 8'd73;
	localparam logic [VOLT_W-1:0] VOLT_MAX     = 10'd1023;
	localparam logic [ACC_W-1:0]  ACC_MAX      = 12'd4095;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STARTUP_LOW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STARTUP_HIGH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN_LOW  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN_HIGH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_ENABLE  = 3'd5;

	// Status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_ABOVE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BELOW = 2'd2;

	typedef logic [VOLT_W-1:0] volt_t;

endpackage
`default_nettype wire

/* design/svm_if.sv */
// Channel interfaces of the supply voltage monitor: sample, result, configuration.
`timescale 1ns / 1ps
`default_nettype none
interface svm_sample_if;
	logic                          valid;
	logic                          ready;
	logic [svm_pkg::SAMPLE_W-1:0]  adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink   (input valid, input adc_sample, output ready);
endinterface

interface svm_result_if;
	logic                        valid;
	logic                        ready;
	svm_pkg::volt_t              filtered_voltage;
	logic                        pwr_ok;
	logic [svm_pkg::STAT_W-1:0]  status;

	modport source (output valid, output filtered_voltage, output pwr_ok,
		output status, input ready);
	modport sink   (input valid, input filtered_voltage, input pwr_ok,
		input status, output ready);
endinterface

interface svm_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [svm_pkg::CFG_IDX_W-1:0]   index;
	logic [svm_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* design/supply_voltage_monitor.sv */
// Supply voltage monitor: leaky integrator filter with a hysteresis power-good window.
//
//   channel  dir  handshake     payload
//   sample   in   valid/ready   adc_sample[11:0]
//   result   out  valid/ready   filtered_voltage[9:0], pwr_ok, status[1:0]
//   cfg      in   valid/ready   index[2:0], data[9:0]
//
// One sample per cycle unless the result side stalls: clamp, 10x8 gain multiply,
// integrator add and the window compares all sit between the input handshake and
// the result register. A result appears in the cycle after its sample is accepted.
// The sample side stays ready while the result register is empty or being taken.
// Reset clears the integrator and power-good and loads the register defaults.
// Configuration writes are always ready and take effect on the next sample.
`timescale 1ns / 1ps
`default_nettype none
module supply_voltage_monitor (
	input  wire logic          clk,
	input  wire logic          arst_n,
	svm_sample_if.sink         sample,
	svm_result_if.source       result,
	svm_cfg_if.sink            cfg
);

	logic [svm_pkg::GAIN_W-1:0] gain_q;
	svm_pkg::volt_t             startup_low_q;
	svm_pkg::volt_t             startup_high_q;
	svm_pkg::volt_t             shutdown_low_q;
	svm_pkg::volt_t             shutdown_high_q;
	logic                       check_enable_q;

	logic [svm_pkg::ACC_W-1:0]  acc_q;
	logic                       good_q;
	logic                       out_valid_q;
	svm_pkg::volt_t             volt_q;
	logic                       pg_q;
	logic [svm_pkg::STAT_W-1:0] stat_q;

	logic                       take;
	svm_pkg::volt_t             shifted;
	svm_pkg::volt_t             clamped;
	logic [svm_pkg::VOLT_W+svm_pkg::GAIN_W-1:0] product;
	svm_pkg::volt_t             scaled;
	svm_pkg::volt_t             last_out;
	logic signed [svm_pkg::ACC_W+1:0] sum;
	logic [svm_pkg::ACC_W-1:0]  acc_next;
	svm_pkg::volt_t             volt_next;
	logic                       good_next;
	logic [svm_pkg::STAT_W-1:0] stat_next;

	assign cfg.ready    = 1'b1;
	assign sample.ready = !out_valid_q || result.ready;
	assign take         = sample.valid && sample.ready;

	// Previous filtered output is always the accumulator over four.
	assign last_out = acc_q[svm_pkg::ACC_W-1:2];

	always_comb begin
		shifted = sample.adc_sample[svm_pkg::SAMPLE_W-1:2];
		clamped = (shifted > svm_pkg::SAMPLE_CLAMP) ? svm_pkg::SAMPLE_CLAMP : shifted;
		product = clamped * gain_q;
		scaled  = product[svm_pkg::VOLT_W+svm_pkg::GAIN_W-1:svm_pkg::GAIN_W];
		sum = $signed({2'b00, acc_q}) + $signed({4'b0000, scaled})
			- $signed({4'b0000, last_out});
		if (sum < 0) begin
			acc_next = '0;
		end else if (sum > $signed({2'b00, svm_pkg::ACC_MAX})) begin
			acc_next = svm_pkg::ACC_MAX;
		end else begin
			acc_next = sum[svm_pkg::ACC_W-1:0];
		end
		volt_next = acc_next[svm_pkg::ACC_W-1:2];

		// Hysteresis in priority order: shutdown low, startup window, shutdown high.
		if (volt_next < shutdown_low_q) begin
			good_next = 1'b0;
		end else if (volt_next >= startup_low_q && volt_next <= startup_high_q) begin
			good_next = 1'b1;
		end else if (volt_next > shutdown_high_q) begin
			good_next = 1'b0;
		end else begin
			good_next = good_q;
		end

		if (!check_enable_q) begin
			stat_next = svm_pkg::STAT_OK;
		end else if (volt_next > startup_high_q) begin
			stat_next = svm_pkg::STAT_ABOVE;
		end else if (volt_next < startup_low_q) begin
			stat_next = svm_pkg::STAT_BELOW;
		end else begin
			stat_next = svm_pkg::STAT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q          <= svm_pkg::GAIN_RESET;
			startup_low_q   <= '0;
			startup_high_q  <= svm_pkg::VOLT_MAX;
			shutdown_low_q  <= '0;
			shutdown_high_q <= svm_pkg::VOLT_MAX;
			check_enable_q  <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				svm_pkg::REG_GAIN:          gain_q <= cfg.data[svm_pkg::GAIN_W-1:0];
				svm_pkg::REG_STARTUP_LOW:   startup_low_q <= cfg.data;
				svm_pkg::REG_STARTUP_HIGH:  startup_high_q <= cfg.data;
				svm_pkg::REG_SHUTDOWN_LOW:  shutdown_low_q <= cfg.data;
				svm_pkg::REG_SHUTDOWN_HIGH: shutdown_high_q <= cfg.data;
				svm_pkg::REG_CHECK_ENABLE:  check_enable_q <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			good_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				acc_q       <= acc_next;
				good_q      <= good_next;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			volt_q <= volt_next;
			pg_q   <= check_enable_q ? good_next : 1'b1;
			stat_q <= stat_next;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.filtered_voltage = volt_q;
	assign result.pwr_ok           = pg_q;
	assign result.status           = stat_q;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> result.valid)
		else $error("accepted sample produced no result");

	a_result_matches_acc: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> result.filtered_voltage == acc_q[svm_pkg::ACC_W-1:2])
		else $error("filtered output does not match integrator state");

	a_shutdown_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && volt_next < shutdown_low_q |=> !good_q)
		else $error("power-good not cleared below shutdown low");

endmodule
`default_nettype wire
